// ===== hdl/cfp_pkg.sv =====
// Package: shared types and constants for the console frame parser.
`default_nettype none

package cfp_pkg;

   typedef enum logic [2:0] {
      KIND_CMD    = 3'd0,
      KIND_PARAM  = 3'd1,
      KIND_PEND   = 3'd2,
      KIND_DATA   = 3'd3,
      KIND_STATUS = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_NO_START   = 4'd1,
      ST_BAD_ID     = 4'd2,
      ST_BAD_LEN    = 4'd3,
      ST_BAD_BODY   = 4'd4,
      ST_BAD_CMD    = 4'd5,
      ST_BAD_PARAMS = 4'd6,
      ST_BAD_END    = 4'd7,
      ST_LEN_ERR    = 4'd8,
      ST_XOR_ERR    = 4'd9
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_AFTER_LT = 4'd1,
      PH_ID_SKIP  = 4'd2,
      PH_ID_NUM   = 4'd3,
      PH_LEN_SKIP = 4'd4,
      PH_LEN_NUM  = 4'd5,
      PH_BODY     = 4'd6,
      PH_CMD_SKIP = 4'd7,
      PH_CMD      = 4'd8,
      PH_PAR_SKIP = 4'd9,
      PH_PAR      = 4'd10,
      PH_END      = 4'd11,
      PH_XCRC     = 4'd12,
      PH_XDATA    = 4'd13,
      PH_DONE     = 4'd14
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
      status_type code;
      logic [15:0] frame_id;
      logic [15:0] declared_length;
      logic [15:0] measured_length;
      logic        is_transfer;
      logic [7:0]  param_count;
      logic        last_of_run;
   } result_type;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [7:0]  PCOUNT_MAX = 8'hFF;

endpackage

`default_nettype wire

// ===== hdl/cfp_parser.sv =====
// Parser state machine: per-byte step, state registers, token and status results.
`default_nettype none

module cfp_parser #(
   parameter int NUMBER_WIDTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   output cfp_pkg::result_type     res0,
   output cfp_pkg::result_type     res1,
   output logic [1:0]              res_count
);
   import cfp_pkg::*;

   localparam int AccW  = NUMBER_WIDTH + 4;
   localparam int WideW = NUMBER_WIDTH + 16;
   localparam logic [NUMBER_WIDTH-1:0] NumMax = {NUMBER_WIDTH{1'b1}};

   phase_type               phase_ff, phase_in;
   logic [NUMBER_WIDTH-1:0] id_ff, id_in;
   logic [NUMBER_WIDTH-1:0] len_ff, len_in;
   logic [15:0]             cnt_ff, cnt_in;
   logic                    quotes_ff, quotes_in;
   logic [7:0]              rx_ff, rx_in;
   logic [7:0]              ex_ff, ex_in;
   logic [7:0]              pc_ff, pc_in;
   logic                    sent_ff, sent_in;
   status_type              held_ff, held_in;

   logic [15:0]             cnt_inc;
   logic                    is_digit, is_space, is_pct, is_gt, len_match;
   logic                    decide;
   status_type              dcode;
   logic                    tok_en;
   kind_type                tok_kind;
   logic [7:0]              tok_char;
   status_type              end_code;
   logic [WideW-1:0]        id_ext, len_ext, cnt_ext, lin_ext;
   result_type              tok_res, stat_res;

   function automatic logic [NUMBER_WIDTH-1:0] acc_digit(
      input logic [NUMBER_WIDTH-1:0] v,
      input logic [7:0]              c
   );
      logic [AccW-1:0] t;
      t = (AccW'(v) << 3) + (AccW'(v) << 1) + AccW'(c - CH_ZERO);
      if (t[AccW-1:NUMBER_WIDTH] != '0) begin
         return NumMax;
      end
      return t[NUMBER_WIDTH-1:0];
   endfunction

   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign is_space = (data_byte == CH_SPACE);
   assign is_pct   = (data_byte == CH_PCT);
   assign is_gt    = (data_byte == CH_GT);

   assign cnt_inc = (phase_ff != PH_IDLE && !sent_ff && cnt_ff != COUNT_MAX) ?
                    cnt_ff + 16'd1 : cnt_ff;
   assign len_ext   = WideW'(len_ff);
   assign cnt_ext   = WideW'(cnt_inc);
   assign len_match = (len_ext == cnt_ext);

   // next phase and frame decisions
   always_comb begin
      phase_in = phase_ff;
      decide   = 1'b0;
      dcode    = ST_OK;
      unique case (phase_ff)
         PH_IDLE: begin
            if (data_byte == CH_LT) phase_in = PH_AFTER_LT;
         end
         PH_AFTER_LT: begin
            if (data_byte == CH_HASH) phase_in = PH_XCRC;
            else if (is_space) phase_in = PH_ID_SKIP;
            else if (is_digit) phase_in = PH_ID_NUM;
            else begin decide = 1'b1; dcode = ST_BAD_ID; end
         end
         PH_ID_SKIP: begin
            if (is_digit) phase_in = PH_ID_NUM;
            else if (!is_space) begin decide = 1'b1; dcode = ST_BAD_ID; end
         end
         PH_ID_NUM: begin
            if (is_space) phase_in = PH_LEN_SKIP;
            else if (!is_digit) begin decide = 1'b1; dcode = ST_BAD_ID; end
         end
         PH_LEN_SKIP: begin
            if (is_digit) phase_in = PH_LEN_NUM;
            else if (!is_space) begin decide = 1'b1; dcode = ST_BAD_LEN; end
         end
         PH_LEN_NUM: begin
            if (is_space) phase_in = PH_BODY;
            else if (!is_digit) begin decide = 1'b1; dcode = ST_BAD_LEN; end
         end
         PH_BODY: begin
            if (is_pct) phase_in = PH_CMD_SKIP;
            else if (!is_space) begin decide = 1'b1; dcode = ST_BAD_BODY; end
         end
         PH_CMD_SKIP: begin
            if (is_pct || is_gt) begin decide = 1'b1; dcode = ST_BAD_CMD; end
            else if (!is_space) phase_in = PH_CMD;
         end
         PH_CMD: begin
            if (is_space) phase_in = PH_PAR_SKIP;
            else if (is_pct) phase_in = PH_END;
            else if (is_gt) begin decide = 1'b1; dcode = ST_BAD_CMD; end
         end
         PH_PAR_SKIP: begin
            if (is_pct) phase_in = PH_END;
            else if (is_gt) begin decide = 1'b1; dcode = ST_BAD_PARAMS; end
            else if (!is_space) phase_in = PH_PAR;
         end
         PH_PAR: begin
            if ((quotes_ff && data_byte == CH_QUOTE) || (!quotes_ff && is_space))
               phase_in = PH_PAR_SKIP;
            else if (is_pct) phase_in = PH_END;
            else if (is_gt) begin decide = 1'b1; dcode = ST_BAD_PARAMS; end
         end
         PH_END: begin
            if (is_gt) begin
               decide = 1'b1;
               dcode  = len_match ? ST_OK : ST_LEN_ERR;
            end else if (!is_space) begin
               decide = 1'b1;
               dcode  = ST_BAD_END;
            end
         end
         PH_XCRC: phase_in = PH_XDATA;
         PH_XDATA: phase_in = PH_XDATA;
         PH_DONE: phase_in = PH_DONE;
         default: phase_in = phase_ff;
      endcase
      if (decide) phase_in = PH_DONE;
   end

   // datapath updates and tokens
   always_comb begin
      id_in     = id_ff;
      len_in    = len_ff;
      cnt_in    = cnt_inc;
      quotes_in = quotes_ff;
      rx_in     = rx_ff;
      ex_in     = ex_ff;
      pc_in     = pc_ff;
      tok_en    = 1'b0;
      tok_kind  = KIND_CMD;
      tok_char  = data_byte;
      unique case (phase_ff)
         PH_IDLE: begin
            if (data_byte == CH_LT) cnt_in = 16'd1;
         end
         PH_AFTER_LT, PH_ID_SKIP: begin
            if (is_digit) id_in = acc_digit('0, data_byte);
         end
         PH_ID_NUM: begin
            if (is_digit) id_in = acc_digit(id_ff, data_byte);
         end
         PH_LEN_SKIP: begin
            if (is_digit) len_in = acc_digit('0, data_byte);
         end
         PH_LEN_NUM: begin
            if (is_digit) len_in = acc_digit(len_ff, data_byte);
         end
         PH_CMD_SKIP, PH_CMD: begin
            if (!is_space && !is_pct && !is_gt) begin
               tok_en   = 1'b1;
               tok_kind = KIND_CMD;
            end
         end
         PH_PAR_SKIP: begin
            if (!is_pct && !is_space && !is_gt) begin
               if (pc_ff != PCOUNT_MAX) pc_in = pc_ff + 8'd1;
               if (data_byte == CH_QUOTE) begin
                  quotes_in = 1'b1;
               end else begin
                  quotes_in = 1'b0;
                  tok_en    = 1'b1;
                  tok_kind  = KIND_PARAM;
               end
            end
         end
         PH_PAR: begin
            if ((quotes_ff && data_byte == CH_QUOTE) || (!quotes_ff && is_space) ||
                is_pct) begin
               tok_en    = 1'b1;
               tok_kind  = KIND_PEND;
               tok_char  = 8'd0;
               quotes_in = 1'b0;
            end else if (!is_gt) begin
               tok_en   = 1'b1;
               tok_kind = KIND_PARAM;
            end
         end
         PH_XCRC: begin
            ex_in = data_byte;
            rx_in = 8'd0;
         end
         PH_XDATA: begin
            rx_in    = rx_ff ^ data_byte;
            tok_en   = 1'b1;
            tok_kind = KIND_DATA;
         end
         PH_BODY, PH_END, PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign sent_in = sent_ff | decide;
   assign held_in = decide ? dcode : held_ff;

   always_comb begin
      if (sent_in) begin
         end_code = held_in;
      end else begin
         unique case (phase_in)
            PH_IDLE: end_code = ST_NO_START;
            PH_AFTER_LT, PH_ID_SKIP, PH_ID_NUM: end_code = ST_BAD_ID;
            PH_LEN_SKIP, PH_LEN_NUM: end_code = ST_BAD_LEN;
            PH_BODY: end_code = ST_BAD_BODY;
            PH_CMD_SKIP, PH_CMD: end_code = ST_BAD_CMD;
            PH_PAR_SKIP, PH_PAR: end_code = ST_BAD_PARAMS;
            PH_XCRC: end_code = ST_OK;
            PH_XDATA: end_code = (rx_in == ex_in) ? ST_OK : ST_XOR_ERR;
            default: end_code = ST_BAD_END;
         endcase
      end
   end

   assign id_ext  = WideW'(id_in);
   assign lin_ext = WideW'(len_in);

   always_comb begin
      tok_res      = '0;
      tok_res.kind = tok_kind;
      tok_res.chr  = tok_char;

      stat_res                 = '0;
      stat_res.kind            = KIND_STATUS;
      stat_res.code            = end_code;
      stat_res.frame_id        = id_ext[15:0];
      stat_res.declared_length = lin_ext[15:0];
      stat_res.measured_length = cnt_in;
      stat_res.is_transfer     = (phase_in == PH_XCRC) || (phase_in == PH_XDATA);
      stat_res.param_count     = pc_in;
      stat_res.last_of_run     = 1'b1;
   end

   assign res0      = tok_en ? tok_res : stat_res;
   assign res1      = stat_res;
   assign res_count = {1'b0, tok_en} + {1'b0, last_byte};

   always_ff @(posedge clock) begin
      if (reset || (advance && last_byte)) begin
         phase_ff  <= PH_IDLE;
         id_ff     <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         quotes_ff <= 1'b0;
         rx_ff     <= '0;
         ex_ff     <= '0;
         pc_ff     <= '0;
         sent_ff   <= 1'b0;
         held_ff   <= ST_OK;
      end else if (advance) begin
         phase_ff  <= phase_in;
         id_ff     <= id_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         quotes_ff <= quotes_in;
         rx_ff     <= rx_in;
         ex_ff     <= ex_in;
         pc_ff     <= pc_in;
         sent_ff   <= sent_in;
         held_ff   <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cfp_out_queue.sv =====
// Two-entry result queue: takes up to two results per cycle, sends one.
`default_nettype none

module cfp_out_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_count,
   input  wire cfp_pkg::result_type  push0,
   input  wire cfp_pkg::result_type  push1,
   input  wire logic                 pop,
   output cfp_pkg::result_type       head,
   output logic                      head_valid,
   output logic [1:0]                level
);
   import cfp_pkg::*;

   result_type q0_ff, q0_in;
   result_type q1_ff, q1_in;
   logic [1:0] level_ff, level_in;
   logic [1:0] kept;

   assign kept     = level_ff - {1'b0, pop};
   assign level_in = kept + push_count;

   always_comb begin
      q0_in = q0_ff;
      if (kept != 2'd0) begin
         if (pop) q0_in = q1_ff;
      end else if (push_count != 2'd0) begin
         q0_in = push0;
      end
      if (kept == 2'd2) q1_in = q1_ff;
      else if (kept == 2'd1) q1_in = push0;
      else q1_in = push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign head       = q0_ff;
   assign head_valid = (level_ff != 2'd0);
   assign level      = level_ff;

endmodule

`default_nettype wire

// ===== hdl/console_frame_parser_top.sv =====
// Top level: console frame parser with input register and result queue.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | data_byte, last_byte
//   rsp     | out       | rsp_valid/rsp_stall | out_kind .. last_of_run
//
// One byte per cycle unless req_stall is high: a byte is registered, then parsed
// and its results (a token, a status, or both) enter a two-entry result queue.
// A byte holds the input register while the queue cannot take all of its results,
// as when it yields two and the queue is not empty; the queue depth sets this.
// Synchronous active-high reset returns the parser to waiting for '<'.
// rsp_stall backs up through the queue into req_stall.
`default_nettype none

module console_frame_parser_top #(
   parameter int NUMBER_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_char,
   output logic [3:0]       rsp_status_code,
   output logic [15:0]      rsp_frame_id,
   output logic [15:0]      rsp_declared_length,
   output logic [15:0]      rsp_measured_length,
   output logic             rsp_is_transfer,
   output logic [7:0]       rsp_param_count,
   output logic             rsp_last_of_run
);
   import cfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance, pop;
   logic [1:0] res_count, push_count, level, kept;
   logic [2:0] need;
   result_type res0, res1, head;

   cfp_parser #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   assign pop        = rsp_valid && !rsp_stall;
   assign kept       = level - {1'b0, pop};
   assign need       = {1'b0, kept} + {1'b0, res_count};
   assign advance    = in_valid_ff && (need <= 3'd2);
   assign push_count = advance ? res_count : 2'd0;
   assign req_stall  = in_valid_ff && !advance;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   cfp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .pop        (pop),
      .head       (head),
      .head_valid (rsp_valid),
      .level      (level)
   );

   assign rsp_out_kind        = head.kind;
   assign rsp_out_char        = head.chr;
   assign rsp_status_code     = head.code;
   assign rsp_frame_id        = head.frame_id;
   assign rsp_declared_length = head.declared_length;
   assign rsp_measured_length = head.measured_length;
   assign rsp_is_transfer     = head.is_transfer;
   assign rsp_param_count     = head.param_count;
   assign rsp_last_of_run     = head.last_of_run;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for console_frame_parser_top: random console buffers, predicted tokens, checks.
`timescale 1ns / 100ps

module tb;
   import cfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam logic [7:0] SYNTAX_CHARS [6] = '{CH_SPACE, CH_PCT, CH_GT, CH_QUOTE, CH_LT,
                                                CH_HASH};

   typedef struct packed {
      logic [7:0] value;
      logic       eob;
   } rx_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_out_kind;
   logic [7:0]  rsp_out_char;
   logic [3:0]  rsp_status_code;
   logic [15:0] rsp_frame_id;
   logic [15:0] rsp_declared_length;
   logic [15:0] rsp_measured_length;
   logic        rsp_is_transfer;
   logic [7:0]  rsp_param_count;
   logic        rsp_last_of_run;

   console_frame_parser_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_out_char       (rsp_out_char),
      .rsp_status_code    (rsp_status_code),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_declared_length(rsp_declared_length),
      .rsp_measured_length(rsp_measured_length),
      .rsp_is_transfer    (rsp_is_transfer),
      .rsp_param_count    (rsp_param_count),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   rx_byte_type pending_bytes[$];
   result_type  predicted_tokens[$];
   logic [7:0]  frame_bytes[$];
   rx_byte_type next_byte;
   result_type  got, exp_res;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  req_done = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  bytes_in = 0;
   int  phase_bytes = 0;
   int  errors = 0;
   int  tokens_seen = 0;
   int  transfers_seen = 0;
   int  status_seen[16];
   int  quiet_cycles = 0;

   // parser state mirror
   phase_type   ph = PH_IDLE;
   logic [15:0] idv = '0;
   logic [15:0] lenv = '0;
   logic [15:0] bcnt = '0;
   bit          inq = 1'b0;
   logic [7:0]  xr = '0;
   logic [7:0]  xexp = '0;
   logic [7:0]  pcount = '0;
   bit          decided = 1'b0;
   status_type  held = ST_OK;

   function automatic logic [15:0] next_digit(logic [15:0] v, logic [7:0] c);
      int unsigned t;
      t = 32'(v) * 10 + 32'(c) - 32'(CH_ZERO);
      return (t > 32'(COUNT_MAX)) ? COUNT_MAX : t[15:0];
   endfunction

   task automatic settle(input status_type code);
      held = code;
      decided = 1'b1;
      ph = PH_DONE;
   endtask

   task automatic emit(input kind_type k, input logic [7:0] ch);
      result_type r;
      r = '0;
      r.kind = k;
      r.chr = ch;
      predicted_tokens.push_back(r);
   endtask

   task automatic parse_byte(input logic [7:0] c, input logic lst);
      result_type r;
      bit dig;
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      if (ph != PH_IDLE && !decided && bcnt != COUNT_MAX) bcnt++;
      case (ph)
         PH_IDLE: if (c == CH_LT) begin
            bcnt = 16'd1;
            ph = PH_AFTER_LT;
         end
         PH_AFTER_LT, PH_ID_SKIP: begin
            if (ph == PH_AFTER_LT && c == CH_HASH) ph = PH_XCRC;
            else if (c == CH_SPACE) ph = PH_ID_SKIP;
            else if (dig) begin
               idv = next_digit(16'd0, c);
               ph = PH_ID_NUM;
            end else settle(ST_BAD_ID);
         end
         PH_ID_NUM: begin
            if (c == CH_SPACE) ph = PH_LEN_SKIP;
            else if (dig) idv = next_digit(idv, c);
            else settle(ST_BAD_ID);
         end
         PH_LEN_SKIP: begin
            if (dig) begin
               lenv = next_digit(16'd0, c);
               ph = PH_LEN_NUM;
            end else if (c != CH_SPACE) settle(ST_BAD_LEN);
         end
         PH_LEN_NUM: begin
            if (c == CH_SPACE) ph = PH_BODY;
            else if (dig) lenv = next_digit(lenv, c);
            else settle(ST_BAD_LEN);
         end
         PH_BODY: begin
            if (c == CH_PCT) ph = PH_CMD_SKIP;
            else if (c != CH_SPACE) settle(ST_BAD_BODY);
         end
         PH_CMD_SKIP: begin
            if (c == CH_PCT || c == CH_GT) settle(ST_BAD_CMD);
            else if (c != CH_SPACE) begin
               emit(KIND_CMD, c);
               ph = PH_CMD;
            end
         end
         PH_CMD: begin
            if (c == CH_SPACE) ph = PH_PAR_SKIP;
            else if (c == CH_PCT) ph = PH_END;
            else if (c == CH_GT) settle(ST_BAD_CMD);
            else emit(KIND_CMD, c);
         end
         PH_PAR_SKIP: begin
            if (c == CH_PCT) ph = PH_END;
            else if (c == CH_GT) settle(ST_BAD_PARAMS);
            else if (c != CH_SPACE) begin
               if (pcount != PCOUNT_MAX) pcount++;
               ph = PH_PAR;
               if (c == CH_QUOTE) inq = 1'b1;
               else begin
                  inq = 1'b0;
                  emit(KIND_PARAM, c);
               end
            end
         end
         PH_PAR: begin
            if ((inq && c == CH_QUOTE) || (!inq && c == CH_SPACE)) begin
               emit(KIND_PEND, 8'h00);
               inq = 1'b0;
               ph = PH_PAR_SKIP;
            end else if (c == CH_PCT) begin
               // percent also closes an open quote and ends the list
               emit(KIND_PEND, 8'h00);
               inq = 1'b0;
               ph = PH_END;
            end else if (c == CH_GT) settle(ST_BAD_PARAMS);
            else emit(KIND_PARAM, c);
         end
         PH_END: begin
            if (c == CH_GT) settle((bcnt == lenv) ? ST_OK : ST_LEN_ERR);
            else if (c != CH_SPACE) settle(ST_BAD_END);
         end
         PH_XCRC: begin
            xexp = c;
            xr = 8'h00;
            ph = PH_XDATA;
         end
         PH_XDATA: begin
            xr ^= c;
            emit(KIND_DATA, c);
         end
         default: ;
      endcase
      if (lst) begin
         r = '0;
         r.kind = KIND_STATUS;
         if (decided) r.code = held;
         else begin
            case (ph)
               PH_IDLE:                            r.code = ST_NO_START;
               PH_AFTER_LT, PH_ID_SKIP, PH_ID_NUM: r.code = ST_BAD_ID;
               PH_LEN_SKIP, PH_LEN_NUM:            r.code = ST_BAD_LEN;
               PH_BODY:                            r.code = ST_BAD_BODY;
               PH_CMD_SKIP, PH_CMD:                r.code = ST_BAD_CMD;
               PH_PAR_SKIP, PH_PAR:                r.code = ST_BAD_PARAMS;
               PH_XCRC:                            r.code = ST_OK;
               PH_XDATA:  r.code = (xr == xexp) ? ST_OK : ST_XOR_ERR;
               default:                            r.code = ST_BAD_END;
            endcase
         end
         r.frame_id = idv;
         r.declared_length = lenv;
         r.measured_length = bcnt;
         r.is_transfer = (ph == PH_XCRC || ph == PH_XDATA);
         r.param_count = pcount;
         r.last_of_run = 1'b1;
         predicted_tokens.push_back(r);
         ph = PH_IDLE;
         idv = '0;
         lenv = '0;
         bcnt = '0;
         inq = 1'b0;
         xr = '0;
         xexp = '0;
         pcount = '0;
         decided = 1'b0;
         held = ST_OK;
      end
   endtask

   // ---------------- stimulus building ----------------
   task automatic add_chr(input logic [7:0] c);
      frame_bytes.push_back(c);
   endtask

   task automatic add_spaces(input int n);
      repeat (n) add_chr(CH_SPACE);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) add_chr(8'(s[i]));
   endtask

   function automatic logic [7:0] text_char(bit in_quotes);
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(33, 126));
         if (in_quotes && $urandom_range(0, 3) == 0) c = CH_SPACE;
      end while (c == CH_PCT || c == CH_GT || c == CH_QUOTE || (!in_quotes && c == CH_SPACE));
      return c;
   endfunction

   task automatic queue_buffer(input bit with_junk);
      rx_byte_type it;
      logic [7:0]  b;
      phase_bytes += frame_bytes.size();
      if (with_junk) begin
         repeat ($urandom_range(0, 2)) begin
            do b = 8'($urandom); while (b == CH_LT);
            frame_bytes.push_front(b);
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add_chr(8'($urandom));
      end
      for (int i = 0; i < frame_bytes.size(); i++) begin
         it.value = frame_bytes[i];
         it.eob = (i == frame_bytes.size() - 1);
         pending_bytes.push_back(it);
      end
      frame_bytes = {};
   endtask

   task automatic build_command(input bit flood);
      int len_w, len_pos, nparams, lv;
      bit quoted, unclosed;
      frame_bytes = {};
      unclosed = 1'b0;
      len_w = flood ? 5 : $urandom_range(2, 3);
      add_chr(CH_LT);
      add_spaces($urandom_range(0, 1));
      repeat ($urandom_range(1, 7)) add_chr(CH_ZERO + 8'($urandom_range(0, 9)));
      add_spaces($urandom_range(1, 2));
      len_pos = frame_bytes.size();
      repeat (len_w) add_chr(CH_ZERO);
      add_spaces($urandom_range(1, 2));
      add_chr(CH_PCT);
      add_spaces($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) add_chr(text_char(1'b0));
      nparams = flood ? $urandom_range(256, 300) : $urandom_range(0, 4);
      for (int i = 0; i < nparams; i++) begin
         add_spaces(flood ? 1 : $urandom_range(1, 2));
         quoted = !flood && ($urandom_range(0, 2) == 0);
         if (quoted) begin
            add_chr(CH_QUOTE);
            repeat ($urandom_range(0, 6)) add_chr(text_char(1'b1));
            if (i == nparams - 1 && $urandom_range(0, 3) == 0) unclosed = 1'b1;
            else add_chr(CH_QUOTE);
         end else
            repeat (flood ? 1 : $urandom_range(1, 5)) add_chr(text_char(1'b0));
      end
      if (!unclosed) add_spaces($urandom_range(0, 1));
      add_chr(CH_PCT);
      add_spaces($urandom_range(0, 1));
      add_chr(CH_GT);
      lv = frame_bytes.size();
      if ($urandom_range(0, 7) == 0) lv = $urandom_range(0, 999);
      for (int j = len_w - 1; j >= 0; j--) begin
         frame_bytes[len_pos + j] = CH_ZERO + 8'(lv % 10);
         lv = lv / 10;
      end
      case ($urandom_range(0, 9))
         0: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
         1: frame_bytes[$urandom_range(1, frame_bytes.size() - 1)] =
               SYNTAX_CHARS[$urandom_range(0, 5)];
         2: repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
         default: ;
      endcase
   endtask

   task automatic run_random(input int target);
      logic [7:0] sum, b;
      int pick;
      phase_bytes = 0;
      while (phase_bytes < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) build_command(1'b0);
         else if (pick < 85) begin
            frame_bytes = {};
            add_chr(CH_LT);
            add_chr(CH_HASH);
            if ($urandom_range(0, 9) != 0) begin
               sum = 8'h00;
               add_chr(8'h00);
               repeat ($urandom_range(0, 12)) begin
                  b = 8'($urandom);
                  sum ^= b;
                  add_chr(b);
               end
               frame_bytes[2] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : sum;
            end
         end else begin
            frame_bytes = {};
            if ($urandom_range(0, 2) == 0) add_chr(CH_LT);
            repeat ($urandom_range(1, 6)) add_chr(8'($urandom));
         end
         queue_buffer(1'b1);
      end
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid || predicted_tokens.size() != 0)
         @(posedge clock);
   endtask

   // ---------------- request side ----------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         parse_byte(req_data_byte, req_last_byte);
         bytes_in++;
         req_done = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         req_done = 1'b0;
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_byte = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_byte.value;
            req_last_byte <= next_byte.eob;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- result side ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic string fmt_result(result_type r);
      return $sformatf({"kind %0d char %h code %0d id %0d dlen %0d mlen %0d",
                        " xfer %0b pc %0d eob %0b"},
                       r.kind, r.chr, r.code, r.frame_id, r.declared_length,
                       r.measured_length, r.is_transfer, r.param_count, r.last_of_run);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_kind, rsp_out_char, rsp_status_code, rsp_frame_id,
                rsp_declared_length, rsp_measured_length, rsp_is_transfer,
                rsp_param_count, rsp_last_of_run};
         if (predicted_tokens.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected transaction: %s", fmt_result(got));
         end else begin
            exp_res = predicted_tokens.pop_front();
            if (got.kind !== exp_res.kind || got.chr !== exp_res.chr ||
                got.code !== exp_res.code || got.frame_id !== exp_res.frame_id ||
                got.declared_length !== exp_res.declared_length ||
                got.measured_length !== exp_res.measured_length ||
                got.is_transfer !== exp_res.is_transfer ||
                got.param_count !== exp_res.param_count ||
                got.last_of_run !== exp_res.last_of_run) begin
               errors++;
               if (errors <= 10) begin
                  $display("Mismatch at %0t: expected %s", $realtime, fmt_result(exp_res));
                  $display("                 actual   %s", fmt_result(got));
               end
            end
         end
         if (got.kind == KIND_STATUS) begin
            status_seen[got.code]++;
            if (got.is_transfer) transfers_seen++;
         end else begin
            tokens_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- test sequence ----------------
   initial begin
      int mark, other;
      send_idle_pct = 11;
      recv_idle_pct = 49;

      // directed: no start, bare transfer, saturated id, quoted param closed by percent, transfer with data
      add_chr(8'h00);
      queue_buffer(1'b0);
      add_str("<#");
      queue_buffer(1'b0);
      add_str("<70000");
      queue_buffer(1'b0);
      add_str("<1 13 %c \"a%>");
      queue_buffer(1'b0);
      add_str("<#");
      add_chr(8'hFF);
      add_chr(8'h00);
      add_chr(8'hFF);
      queue_buffer(1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drain();
      run_random(200);
      drain();

      send_idle_pct = 49;
      recv_idle_pct = 11;
      build_command(1'b1);
      queue_buffer(1'b0);
      run_random(200);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      mark = bytes_in;
      run_random(200);
      while (bytes_in < mark + 30) @(posedge clock);
      hold_request = 1'b1;
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (predicted_tokens.size() != 0) begin
         errors++;
         $display("%0d expected transactions never arrived", predicted_tokens.size());
      end
      other = 0;
      for (int i = 0; i < 16; i++)
         if (i != ST_OK && i != ST_LEN_ERR && i != ST_XOR_ERR) other += status_seen[i];
      $display("Run covered %0d bytes, %0d tokens and %0d buffer statuses (%0d transfers)",
               bytes_in, tokens_seen, status_seen.sum(), transfers_seen);
      $display("Statuses: ok %0d, length mismatch %0d, checksum error %0d, syntax errors %0d",
               status_seen[ST_OK], status_seen[ST_LEN_ERR], status_seen[ST_XOR_ERR], other);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
